/* rtl/pfr_pkg.sv */
// Shared constants and types for the packet-to-frame-buffer reassembly block.
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int NUM_BUFFERS = 16;
  localparam int BUF_W       = 4;
  localparam int CNT_W       = 5;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  typedef logic [BUF_W-1:0]      buf_id_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // Configuration register indexes
  localparam cfg_idx_t REG_PACKETS_PER_FRAME     = 3'd0;
  localparam cfg_idx_t REG_PRIMARY_PACKET_COUNT  = 3'd1;
  localparam cfg_idx_t REG_PRIMARY_PACKET_BYTES  = 3'd2;
  localparam cfg_idx_t REG_TAIL_PACKET_BYTES     = 3'd3;
  localparam cfg_idx_t REG_HEADER_BYTES          = 3'd4;
  localparam cfg_idx_t REG_TYPE_STRIDE_BYTES     = 3'd5;
  localparam cfg_idx_t REG_SUBFRAME_STRIDE_BYTES = 3'd6;

  // Input word kinds
  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;

endpackage

/* rtl/packet_frame_reassembly_top.sv */
// Packet-to-frame-buffer reassembly: frame table, free buffer queue and payload placement.
`timescale 1ns / 1ps

// Takes one word per clock: busy is always low, so every cycle with start high
// accepts a word. A packet-header word gives exactly one result, strobed by done
// for one cycle, once it has passed the input/product register and the result
// register. A buffer-release word gives no result. The cycle is set
// by the 16-entry frame-table compare feeding the buffer select and count
// increment, and by the four-term offset sum. The three offset products are
// formed at the input register. The free queue is empty after reset: buffers
// must be released before any packet lands outside the drop area.
module packet_frame_reassembly_top
  import pfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // configuration
  input  logic                  cfg_write,
  input  cfg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // input words
  input  logic                  start,
  output logic                  busy,
  input  logic                  kind,
  input  logic [7:0]            packet_type,
  input  logic [7:0]            subframe_number,
  input  logic [15:0]           packet_index,
  input  logic [31:0]           frame_tag,
  input  logic [BUF_W-1:0]      released_buffer,
  // results
  output logic                  done,
  output logic [BUF_W-1:0]      buffer_id,
  output logic                  dropped,
  output logic [31:0]           payload_offset,
  output logic [15:0]           payload_bytes,
  output logic                  new_frame,
  output logic                  frame_complete,
  output logic                  frame_ready,
  output logic [31:0]           ready_frame_tag
);

  // configuration registers
  logic [15:0] packets_per_frame;
  logic [15:0] primary_packet_count;
  logic [15:0] primary_packet_bytes;
  logic [15:0] tail_packet_bytes;
  logic [15:0] header_bytes;
  logic [23:0] type_stride_bytes;
  logic [23:0] subframe_stride_bytes;

  always_ff @(posedge clk) begin
    if (rst) begin
      packets_per_frame     <= 16'd1;
      primary_packet_count  <= '0;
      primary_packet_bytes  <= '0;
      tail_packet_bytes     <= '0;
      header_bytes          <= '0;
      type_stride_bytes     <= '0;
      subframe_stride_bytes <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PACKETS_PER_FRAME:     packets_per_frame     <= cfg_data[15:0];
        REG_PRIMARY_PACKET_COUNT:  primary_packet_count  <= cfg_data[15:0];
        REG_PRIMARY_PACKET_BYTES:  primary_packet_bytes  <= cfg_data[15:0];
        REG_TAIL_PACKET_BYTES:     tail_packet_bytes     <= cfg_data[15:0];
        REG_HEADER_BYTES:          header_bytes          <= cfg_data[15:0];
        REG_TYPE_STRIDE_BYTES:     type_stride_bytes     <= cfg_data;
        REG_SUBFRAME_STRIDE_BYTES: subframe_stride_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic accept;
  assign accept = start && !busy;

  // ---------------- input register with offset products ----------------
  logic             s1_valid;
  logic             s1_kind;
  logic [31:0]      s1_frame;
  logic [BUF_W-1:0] s1_rel;
  logic             s1_primary;
  logic [31:0]      s1_type_off;
  logic [31:0]      s1_sub_off;
  logic [31:0]      s1_pkt_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind     <= kind;
      s1_frame    <= frame_tag;
      s1_rel      <= released_buffer;
      s1_primary  <= packet_index < primary_packet_count;
      s1_type_off <= 32'(type_stride_bytes) * 32'(packet_type);
      s1_sub_off  <= 32'(subframe_stride_bytes) * 32'(subframe_number);
      s1_pkt_off  <= 32'(primary_packet_bytes) * 32'(packet_index);
    end
  end

  // ---------------- frame state ----------------
  logic                  seen_valid, seen_valid_next;
  logic [31:0]           seen_frame, seen_frame_next;
  buf_id_t               current_buffer, current_buffer_next;
  logic                  target_is_drop, target_is_drop_next;
  logic                  dropping_flag, dropping_flag_next;
  logic [BUF_W-1:0]      free_head, free_head_next;
  logic [CNT_W-1:0]      free_count, free_count_next;
  logic [15:0]           drop_count, drop_count_next;
  logic [NUM_BUFFERS-1:0] map_valid, map_valid_next;
  logic [31:0]           map_frame     [NUM_BUFFERS];
  buf_id_t               free_ids      [NUM_BUFFERS];
  logic [15:0]           packet_counts [NUM_BUFFERS];

  logic        is_header, is_release;
  logic        lookup, hit_any, pop, start_drop, push;
  buf_id_t     hit_id, pop_id, buf_sel;
  logic        drop_sel, drop_flag_eff;
  logic [15:0] count_base, count_new;
  logic        complete, ready;
  logic [BUF_W-1:0] free_tail;

  // lowest matching table entry wins
  always_comb begin
    hit_any = 1'b0;
    hit_id  = '0;
    for (int i = NUM_BUFFERS - 1; i >= 0; i--) begin
      if (map_valid[i] && map_frame[i] == s1_frame) begin
        hit_any = 1'b1;
        hit_id  = BUF_W'(i);
      end
    end
  end

  always_comb begin
    is_header  = s1_valid && s1_kind == KIND_HEADER;
    is_release = s1_valid && s1_kind == KIND_RELEASE;
    lookup     = is_header && (!seen_valid || s1_frame != seen_frame);
    pop        = lookup && !hit_any && free_count != '0;
    start_drop = lookup && !hit_any && free_count == '0;
    push       = is_release && free_count != CNT_W'(NUM_BUFFERS);
    free_tail  = free_head + free_count[BUF_W-1:0];
    pop_id     = free_ids[free_head];

    if (pop) begin
      buf_sel = pop_id;
    end else if (lookup && hit_any) begin
      buf_sel = hit_id;
    end else begin
      buf_sel = current_buffer;
    end

    drop_sel = lookup ? start_drop : target_is_drop;

    if (start_drop) begin
      drop_flag_eff = 1'b1;
    end else if (pop) begin
      drop_flag_eff = 1'b0;
    end else begin
      drop_flag_eff = dropping_flag;
    end

    // fresh buffer or fresh drop run counts from zero
    if (drop_sel) begin
      count_base = start_drop ? 16'd0 : drop_count;
    end else begin
      count_base = pop ? 16'd0 : packet_counts[buf_sel];
    end
    count_new = count_base + 16'd1;
    complete  = count_new == packets_per_frame;
    ready     = complete && !drop_flag_eff;

    seen_valid_next     = is_header ? !ready : seen_valid;
    seen_frame_next     = lookup ? s1_frame : seen_frame;
    current_buffer_next = (pop || (lookup && hit_any)) ? buf_sel : current_buffer;
    target_is_drop_next = lookup ? start_drop : target_is_drop;
    dropping_flag_next  = is_header ? drop_flag_eff : dropping_flag;
    drop_count_next     = (is_header && drop_sel) ? count_new : drop_count;
    free_head_next      = pop ? free_head + BUF_W'(1) : free_head;
    if (pop) begin
      free_count_next = free_count - CNT_W'(1);
    end else if (push) begin
      free_count_next = free_count + CNT_W'(1);
    end else begin
      free_count_next = free_count;
    end

    map_valid_next = map_valid;
    if (pop) begin
      map_valid_next[pop_id] = 1'b1;
    end
    // completion frees the entry, even one mapped this same word
    if (is_header && ready) begin
      map_valid_next[buf_sel] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_valid     <= 1'b0;
      seen_frame     <= '0;
      current_buffer <= '0;
      target_is_drop <= 1'b0;
      dropping_flag  <= 1'b0;
      free_head      <= '0;
      free_count     <= '0;
      drop_count     <= '0;
      map_valid      <= '0;
    end else begin
      seen_valid     <= seen_valid_next;
      seen_frame     <= seen_frame_next;
      current_buffer <= current_buffer_next;
      target_is_drop <= target_is_drop_next;
      dropping_flag  <= dropping_flag_next;
      free_head      <= free_head_next;
      free_count     <= free_count_next;
      drop_count     <= drop_count_next;
      map_valid      <= map_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      map_frame[pop_id] <= s1_frame;
    end
    if (is_header && !drop_sel) begin
      packet_counts[buf_sel] <= count_new;
    end
    if (push) begin
      free_ids[free_tail] <= s1_rel;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= is_header;
    end
  end

  always_ff @(posedge clk) begin
    if (is_header) begin
      buffer_id       <= drop_sel ? '0 : buf_sel;
      dropped         <= drop_sel;
      payload_offset  <= 32'(header_bytes) + s1_type_off + s1_sub_off + s1_pkt_off;
      payload_bytes   <= s1_primary ? primary_packet_bytes : tail_packet_bytes;
      new_frame       <= lookup && !hit_any;
      frame_complete  <= complete;
      frame_ready     <= ready;
      ready_frame_tag <= ready ? s1_frame : 32'd0;
    end
  end

`ifndef SYNTHESIS
  a_done_from_header: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(s1_valid && s1_kind == KIND_HEADER))
    else $error("result strobe without a header word");

  a_ready_not_dropped: assert property (@(posedge clk) disable iff (rst)
    done && frame_ready |-> frame_complete && !dropped)
    else $error("frame announced while dropping or incomplete");

  a_free_count_bound: assert property (@(posedge clk) disable iff (rst)
    free_count <= CNT_W'(NUM_BUFFERS))
    else $error("free queue overfilled");

  a_drop_implies_flag: assert property (@(posedge clk) disable iff (rst)
    target_is_drop |-> dropping_flag)
    else $error("drop target without dropping flag");

  a_ready_clears_seen: assert property (@(posedge clk) disable iff (rst)
    is_header && ready |=> !seen_valid && !map_valid[$past(buf_sel)])
    else $error("completed frame left mapped");
`endif

endmodule
